/* sv/kdr_pkg.sv */
// Package for the keyed duty ramp controller: field widths, key vector type,
// register indexes, reset defaults and the preset duty table.
// No dependencies.
package kdr_pkg;

  localparam int DUTY_W = 14;
  localparam int STEP_W = 10;
  localparam int CNT_W  = 4;
  localparam int NUM_PRESETS = 5;
  localparam int NUM_KEYS = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;

  // One bit per key, increase in bit 0, preset e in bit 6.
  typedef struct packed {
    logic [NUM_PRESETS-1:0] preset;
    logic                   dec;
    logic                   inc;
  } kdr_keys_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_DUTY   = 3'd0,
    REG_MAX_DUTY     = 3'd1,
    REG_STEP_DUTY    = 3'd2,
    REG_RAMP_STEP    = 3'd3,
    REG_SETTLE_TICKS = 3'd4
  } kdr_reg_t;

  localparam logic [DUTY_W-1:0] START_DUTY_RST   = 14'd500;
  localparam logic [DUTY_W-1:0] MAX_DUTY_RST     = 14'd1100;
  localparam logic [STEP_W-1:0] STEP_DUTY_RST    = 10'd10;
  localparam logic [STEP_W-1:0] RAMP_STEP_RST    = 10'd1;
  localparam logic [CNT_W-1:0]  SETTLE_TICKS_RST = 4'd2;

  localparam logic [DUTY_W-1:0] PRESET_DUTY [NUM_PRESETS] = '{
    14'd500, 14'd600, 14'd700, 14'd800, 14'd900
  };

endpackage

/* sv/kdr_debounce.sv */
// Debounce for all seven keys: per-key raw level, settle counter and settled
// level, producing one-tick press edges. Depends on kdr_pkg.
module kdr_debounce (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     sample_en,
  input  kdr_pkg::kdr_keys_t       levels,
  input  logic [kdr_pkg::CNT_W-1:0] settle_ticks,
  output kdr_pkg::kdr_keys_t       edges
);

  logic [kdr_pkg::NUM_KEYS-1:0] raw_r, raw_nxt;
  logic [kdr_pkg::NUM_KEYS-1:0] stable_r, stable_nxt;
  logic [kdr_pkg::CNT_W-1:0]    cnt_r   [kdr_pkg::NUM_KEYS];
  logic [kdr_pkg::CNT_W-1:0]    cnt_nxt [kdr_pkg::NUM_KEYS];
  logic [kdr_pkg::NUM_KEYS-1:0] lvl;
  logic [kdr_pkg::NUM_KEYS-1:0] edge_vec;

  assign lvl = levels;

  always_comb begin
    for (int k = 0; k < kdr_pkg::NUM_KEYS; k++) begin
      raw_nxt[k]    = raw_r[k];
      cnt_nxt[k]    = cnt_r[k];
      stable_nxt[k] = stable_r[k];
      edge_vec[k]   = 1'b0;
      // restart the count on a new level, otherwise count up to the limit
      if (lvl[k] != raw_r[k]) begin
        raw_nxt[k] = lvl[k];
        cnt_nxt[k] = '0;
      end else if (cnt_r[k] < settle_ticks) begin
        cnt_nxt[k] = cnt_r[k] + 1'b1;
      end
      if (cnt_nxt[k] >= settle_ticks && stable_r[k] != raw_nxt[k]) begin
        stable_nxt[k] = raw_nxt[k];
        edge_vec[k]   = raw_nxt[k];
      end
    end
  end

  assign edges = kdr_pkg::kdr_keys_t'(edge_vec);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '0;
      stable_r <= '0;
      for (int k = 0; k < kdr_pkg::NUM_KEYS; k++) begin
        cnt_r[k] <= '0;
      end
    end else if (sample_en) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      for (int k = 0; k < kdr_pkg::NUM_KEYS; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  a_stable_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !sample_en |=> $stable(stable_r) && $stable(raw_r))
    else $error("key state moved without a sample");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    sample_en && lvl == raw_r && cnt_r[0] < settle_ticks
    |=> cnt_r[0] == $past(cnt_r[0]) + 1'b1)
    else $error("settle counter of increase key did not advance");

endmodule

/* sv/keyed_duty_ramp_controller.sv */
// Top level of the keyed duty ramp controller: request handshakes, config
// registers, target and ramp logic. Depends on kdr_pkg and kdr_debounce.
//
// Each input request is one control tick carrying the raw levels of seven
// keys (increase, decrease, presets a..e). The block debounces every key,
// turns settled rises into press edges, updates the target duty from them
// and moves the current duty one ramp step toward the target; every tick
// returns one result with both duties and two status flags. The block takes
// one request per clock cycle while its results are taken; the keys of a
// request are debounced into an edge register when it is accepted, and then
// target and current duty are updated from it into the output register. A
// request is still accepted while a finished result waits, as long as the
// edge register is free. Write the configuration registers only while no
// tick is in flight; registers reset to start 500, max 1100, step 10,
// ramp step 1 and 2 settle samples.
module keyed_duty_ramp_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] key_increase, [1] key_decrease,
                                  // [2..6] key_preset_a..e, [7] unused
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [13:0] current_duty, [27:14] target_duty,
                                  // [28] duty_moved, [29] ramping, [31:30] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [kdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DW = kdr_pkg::DUTY_W;

  // configuration registers
  logic [DW-1:0]               start_duty_r, max_duty_r;
  logic [kdr_pkg::STEP_W-1:0]  step_duty_r, ramp_step_r;
  logic [kdr_pkg::CNT_W-1:0]   settle_ticks_r;

  // pipeline control
  logic               in_acc;
  logic               adv;         // output slot can take a new result
  logic               s1_valid_r;
  kdr_pkg::kdr_keys_t s1_edges_r;
  kdr_pkg::kdr_keys_t edges;
  kdr_pkg::kdr_keys_t levels;
  logic               tick;        // edge register moves into the output

  // duty state
  logic [DW-1:0] target_r, target_nxt;
  logic [DW-1:0] current_r, current_nxt;
  logic          out_valid_r;
  logic [DW-1:0] out_cur_r, out_tgt_r;
  logic          out_changed_r, out_ramping_r;

  // target arithmetic
  logic [kdr_pkg::NUM_PRESETS-1:0] pre;
  logic          one_preset;
  logic [DW-1:0] preset_val;
  logic [DW:0]   tgt_inc_sum;
  logic [DW-1:0] tgt_inc_val;
  logic [DW-1:0] tgt_dec_val;

  // ramp arithmetic
  logic [DW:0]   cur_up_sum;
  logic [DW-1:0] cur_up_val;
  logic [DW-1:0] cur_dn_diff;
  logic [DW-1:0] cur_dn_val;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_duty_r   <= kdr_pkg::START_DUTY_RST;
      max_duty_r     <= kdr_pkg::MAX_DUTY_RST;
      step_duty_r    <= kdr_pkg::STEP_DUTY_RST;
      ramp_step_r    <= kdr_pkg::RAMP_STEP_RST;
      settle_ticks_r <= kdr_pkg::SETTLE_TICKS_RST;
    end else if (cfg_valid) begin
      // drop writes to indexes outside the register list
      unique case (cfg_index)
        kdr_pkg::REG_START_DUTY:   start_duty_r   <= cfg_data;
        kdr_pkg::REG_MAX_DUTY:     max_duty_r     <= cfg_data;
        kdr_pkg::REG_STEP_DUTY:    step_duty_r    <= cfg_data[kdr_pkg::STEP_W-1:0];
        kdr_pkg::REG_RAMP_STEP:    ramp_step_r    <= cfg_data[kdr_pkg::STEP_W-1:0];
        kdr_pkg::REG_SETTLE_TICKS: settle_ticks_r <= cfg_data[kdr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the output slot frees when empty or taken; the edge register
  // takes a new request when it is empty or drains into the output.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv || !s1_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = adv && s1_valid_r;

  assign levels = kdr_pkg::kdr_keys_t'(in_tdata[kdr_pkg::NUM_KEYS-1:0]);

  kdr_debounce u_debounce (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_en    (in_acc),
    .levels       (levels),
    .settle_ticks (settle_ticks_r),
    .edges        (edges)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_edges_r <= edges;
    end
  end

  // Target update from this tick's press edges.
  assign pre        = s1_edges_r.preset;
  assign one_preset = (pre != '0) && ((pre & (pre - 1'b1)) == '0);

  always_comb begin
    preset_val = kdr_pkg::PRESET_DUTY[0];
    for (int i = kdr_pkg::NUM_PRESETS - 1; i >= 0; i--) begin
      if (pre[i]) begin
        preset_val = kdr_pkg::PRESET_DUTY[i];
      end
    end
  end

  assign tgt_inc_sum = {1'b0, target_r} + {{(DW + 1 - kdr_pkg::STEP_W){1'b0}}, step_duty_r};
  assign tgt_inc_val = (tgt_inc_sum > {1'b0, max_duty_r}) ? max_duty_r : tgt_inc_sum[DW-1:0];
  assign tgt_dec_val = (target_r > {{(DW - kdr_pkg::STEP_W){1'b0}}, step_duty_r})
                     ? target_r - {{(DW - kdr_pkg::STEP_W){1'b0}}, step_duty_r}
                     : '0;

  always_comb begin
    target_nxt = target_r;
    priority if (one_preset) begin
      target_nxt = preset_val;
    end else if (pre != '0) begin
      // hold: several presets at once are ignored
      target_nxt = target_r;
    end else if (s1_edges_r.inc && !s1_edges_r.dec) begin
      if (target_r == '0) begin
        target_nxt = start_duty_r;
      end else if (target_r < max_duty_r) begin
        target_nxt = tgt_inc_val;
      end
    end else if (s1_edges_r.dec && !s1_edges_r.inc) begin
      target_nxt = (target_r > start_duty_r) ? tgt_dec_val : '0;
    end else begin
      target_nxt = target_r;
    end
  end

  // Ramp current duty toward the new target.
  assign cur_up_sum  = {1'b0, current_r} + {{(DW + 1 - kdr_pkg::STEP_W){1'b0}}, ramp_step_r};
  assign cur_up_val  = (cur_up_sum > {1'b0, target_nxt}) ? target_nxt : cur_up_sum[DW-1:0];
  assign cur_dn_diff = (current_r > {{(DW - kdr_pkg::STEP_W){1'b0}}, ramp_step_r})
                     ? current_r - {{(DW - kdr_pkg::STEP_W){1'b0}}, ramp_step_r}
                     : '0;
  assign cur_dn_val  = (cur_dn_diff < target_nxt) ? target_nxt : cur_dn_diff;

  always_comb begin
    priority if (current_r == '0 && target_nxt >= start_duty_r) begin
      current_nxt = start_duty_r;
    end else if (current_r < target_nxt) begin
      current_nxt = cur_up_val;
    end else if (current_r > target_nxt) begin
      if (target_nxt == '0 && current_r <= start_duty_r) begin
        current_nxt = '0;
      end else begin
        current_nxt = cur_dn_val;
      end
    end else begin
      current_nxt = current_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= '0;
      current_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (tick) begin
        target_r  <= target_nxt;
        current_r <= current_nxt;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      out_cur_r     <= current_nxt;
      out_tgt_r     <= target_nxt;
      out_changed_r <= (current_nxt != current_r);
      out_ramping_r <= (current_nxt != target_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_ramping_r, out_changed_r, out_tgt_r, out_cur_r};

  a_duty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !tick |=> $stable(current_r) && $stable(target_r))
    else $error("duty state moved without a tick");

  a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_edges_r))
    else $error("pending edges lost while output stalled");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> out_cur_r == current_r && out_tgt_r == target_r)
    else $error("result register out of step with duty state");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule
